// ----- design/hbsq_pkg.sv -----
// hbsq_pkg: shared types, constants and register indexes for the
// handlebar button and steering qualifier; no dependencies
`default_nettype none

package hbsq_pkg;

  // default parameter values
  localparam int DEFAULT_COUNT_LIMIT     = 100;
  localparam int DEFAULT_DRIFT_FRAC_BITS = 8;

  // fixed widths
  localparam int CNT_W   = 7;
  localparam int CALIB_W = 6;
  localparam int DEN_W   = 7;

  // constants
  localparam logic [7:0]         IDLE_BUTTONS = 8'hf0;
  localparam logic [CNT_W-1:0]   REPEAT_AFTER = 7'd5;
  localparam logic [CNT_W-1:0]   SINGLE_AFTER = 7'd4;
  localparam logic [7:0]         CENTRE_RESET = 8'd128;
  localparam logic [CALIB_W-1:0] CALIB_MAX    = 6'd63;
  localparam logic [DEN_W-1:0]   DRIFT_DIV    = 7'd10;

  // register indexes
  localparam logic [2:0] REG_PLUS_MASK     = 3'd0;
  localparam logic [2:0] REG_MINUS_MASK    = 3'd1;
  localparam logic [2:0] REG_ENTER_MASK    = 3'd2;
  localparam logic [2:0] REG_CANCEL_MASK   = 3'd3;
  localparam logic [2:0] REG_CALIB_SAMPLES = 3'd4;
  localparam logic [2:0] REG_ACTIVE_LIMIT  = 3'd5;
  localparam logic [2:0] REG_NEAR_BAND     = 3'd6;
  localparam logic [2:0] REG_FAR_BAND      = 3'd7;

  // register reset values
  localparam logic [7:0]         RST_PLUS_MASK     = 8'h10;
  localparam logic [7:0]         RST_MINUS_MASK    = 8'h20;
  localparam logic [7:0]         RST_ENTER_MASK    = 8'h40;
  localparam logic [7:0]         RST_CANCEL_MASK   = 8'h80;
  localparam logic [CALIB_W-1:0] RST_CALIB_SAMPLES = 6'd50;
  localparam logic [CNT_W-1:0]   RST_ACTIVE_LIMIT  = 7'd75;
  localparam logic [CNT_W-1:0]   RST_NEAR_BAND     = 7'd10;
  localparam logic [CNT_W-1:0]   RST_FAR_BAND      = 7'd20;

  typedef struct packed {
    logic [7:0] plus_mask;
    logic [7:0] minus_mask;
    logic [7:0] enter_mask;
    logic [7:0] cancel_mask;
  } btn_cfg_t;

  typedef struct packed {
    logic up;
    logic down;
    logic start;
    logic lap;
    logic stop;
  } btn_req_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

`default_nettype wire

// ----- design/handlebar_button_steer_qualifier.sv -----
// handlebar_button_steer_qualifier: poll sample qualifier, top level
// sequence: capture, evaluate, divide when the steering path divides, result;
// the divider takes one bit per cycle
// in_stall holds off a new request until the previous result is registered
// reset: registers to defaults, counters to zero, centre 128, drift 128.0
// depends on hbsq_pkg, hbsq_btn, hbsq_div
`default_nettype none

module handlebar_button_steer_qualifier #(
  parameter int COUNT_LIMIT     = hbsq_pkg::DEFAULT_COUNT_LIMIT,
  parameter int DRIFT_FRAC_BITS = hbsq_pkg::DEFAULT_DRIFT_FRAC_BITS
) (
  input  wire              clk,
  input  wire              rst,
  input  wire              cfg_write,
  input  wire  [2:0]       cfg_index,
  input  wire  [7:0]       cfg_data,
  input  wire              in_valid,
  output logic             in_stall,
  input  wire  [7:0]       button_bits,
  input  wire  [7:0]       steer_sample,
  input  wire              calibrating_flag,
  input  wire              session_running,
  input  wire              session_paused,
  output logic             out_valid,
  input  wire              out_stall,
  output logic             intensity_up,
  output logic             intensity_down,
  output logic             start_request,
  output logic             lap_request,
  output logic             stop_request,
  output logic             scroll_valid,
  output logic signed [2:0] scroll_step,
  output logic [7:0]       centre_value
);
  import hbsq_pkg::*;

  localparam int DRIFT_W = 8 + DRIFT_FRAC_BITS;
  localparam int NUM_W   = DRIFT_W + 4;
  localparam logic [DRIFT_W:0] ONE = (DRIFT_W+1)'(1) << DRIFT_FRAC_BITS;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_EVAL = 3'd1;
  localparam logic [2:0] S_DIV  = 3'd2;
  localparam logic [2:0] S_DONE = 3'd3;

  // configuration
  btn_cfg_t           bcfg;
  logic [CALIB_W-1:0] calib_samples;
  logic [CNT_W-1:0]   active_limit;
  logic [CNT_W-1:0]   near_band;
  logic [CNT_W-1:0]   far_band;

  // state
  logic [2:0]         state;
  logic [CALIB_W-1:0] calib_count;
  logic [CNT_W-1:0]   offcentre_count;
  logic [7:0]         centre_reg;
  logic [DRIFT_W-1:0] drift_reg;

  // captured request
  logic [7:0] btn_in;
  logic [7:0] steer;
  logic       calf;
  logic       run;
  logic       pau;

  // pending result
  btn_req_t         p_btn;
  logic             p_svalid;
  logic signed [2:0] p_step;
  logic             mode_avg;

  btn_req_t   breq;
  div_stat_t  div_stat;
  logic [NUM_W-1:0] quot;
  logic [NUM_W-1:0] div_num;
  logic [DEN_W-1:0] div_den;
  logic             div_start;

  // eval logic
  logic               calibrated;
  logic               off_ok;
  logic               recal;
  logic [7:0]         c_base;
  logic [CALIB_W-1:0] cc_base;
  logic [CALIB_W-1:0] cc_new;
  logic [13:0]        avg_prod;
  logic [8:0]         s9;
  logic [8:0]         c9;
  logic               right_near;
  logic               right_far;
  logic               left_near;
  logic               left_far;

  // drift result
  logic [DRIFT_W-1:0] drift_new;
  logic [DRIFT_W:0]   dn_ext;
  logic [DRIFT_W:0]   cs_ext;
  logic               re_centre;

  logic out_free;

  hbsq_btn #(
    .COUNT_LIMIT(COUNT_LIMIT)
  ) u_btn (
    .clk     (clk),
    .rst     (rst),
    .update  ((state == S_EVAL) && !calf),
    .buttons (btn_in),
    .running (run),
    .paused  (pau),
    .cfg     (bcfg),
    .req     (breq)
  );

  hbsq_div #(
    .NUM_W(NUM_W)
  ) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .numer (div_num),
    .denom (div_den),
    .quot  (quot),
    .stat  (div_stat)
  );

  assign in_stall = (state != S_IDLE);
  assign out_free = !out_valid || !out_stall;

  assign calibrated = (calib_count > calib_samples);
  assign off_ok     = (offcentre_count < active_limit);
  assign recal      = !off_ok;
  assign c_base     = recal ? CENTRE_RESET : centre_reg;
  assign cc_base    = recal ? '0 : calib_count;
  assign cc_new     = (cc_base < CALIB_MAX) ? cc_base + 6'd1 : cc_base;
  assign avg_prod   = 14'(c_base) * 14'(cc_new);

  assign s9         = 9'(steer);
  assign c9         = 9'(centre_reg);
  assign right_near = s9 > c9 + 9'(near_band);
  assign right_far  = s9 > c9 + 9'(far_band);
  assign left_near  = s9 + 9'(near_band) < c9;
  assign left_far   = s9 + 9'(far_band) < c9;

  assign drift_new = quot[DRIFT_W-1:0];
  assign dn_ext    = (DRIFT_W+1)'(drift_new);
  assign cs_ext    = (DRIFT_W+1)'(centre_reg) << DRIFT_FRAC_BITS;
  assign re_centre = (dn_ext > cs_ext + ONE) || (cs_ext > dn_ext + ONE);

  always_comb begin
    div_start = 1'b0;
    div_num   = '0;
    div_den   = DRIFT_DIV;
    if (state == S_EVAL && !calf) begin
      if (calibrated && off_ok) begin
        div_den = DRIFT_DIV;
        div_num = (NUM_W'(drift_reg) << 3) + NUM_W'(drift_reg)
                + (NUM_W'(steer) << DRIFT_FRAC_BITS);
        div_start = !right_near && !left_near;
      end else begin
        div_den   = DEN_W'(cc_new) + 7'd1;
        div_num   = NUM_W'(avg_prod) + NUM_W'(steer);
        div_start = (steer != 8'd0);
      end
    end
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      bcfg.plus_mask   <= RST_PLUS_MASK;
      bcfg.minus_mask  <= RST_MINUS_MASK;
      bcfg.enter_mask  <= RST_ENTER_MASK;
      bcfg.cancel_mask <= RST_CANCEL_MASK;
      calib_samples    <= RST_CALIB_SAMPLES;
      active_limit     <= RST_ACTIVE_LIMIT;
      near_band        <= RST_NEAR_BAND;
      far_band         <= RST_FAR_BAND;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_PLUS_MASK:     bcfg.plus_mask   <= cfg_data;
        REG_MINUS_MASK:    bcfg.minus_mask  <= cfg_data;
        REG_ENTER_MASK:    bcfg.enter_mask  <= cfg_data;
        REG_CANCEL_MASK:   bcfg.cancel_mask <= cfg_data;
        REG_CALIB_SAMPLES: calib_samples    <= cfg_data[CALIB_W-1:0];
        REG_ACTIVE_LIMIT:  active_limit     <= cfg_data[CNT_W-1:0];
        REG_NEAR_BAND:     near_band        <= cfg_data[CNT_W-1:0];
        REG_FAR_BAND:      far_band         <= cfg_data[CNT_W-1:0];
      endcase
    end
  end

  // capture
  always_ff @(posedge clk) begin
    if (state == S_IDLE && in_valid) begin
      btn_in <= button_bits;
      steer  <= steer_sample;
      calf   <= calibrating_flag;
      run    <= session_running;
      pau    <= session_paused;
    end
  end

  // sequencer and steering state
  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= S_IDLE;
      calib_count     <= '0;
      offcentre_count <= '0;
      centre_reg      <= CENTRE_RESET;
      drift_reg       <= DRIFT_W'(CENTRE_RESET) << DRIFT_FRAC_BITS;
      out_valid       <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            state <= S_EVAL;
          end
        end
        S_EVAL: begin
          p_btn    <= calf ? '0 : breq;
          p_svalid <= 1'b0;
          p_step   <= 3'sd0;
          state    <= div_start ? S_DIV : S_DONE;
          if (!calf) begin
            if (calibrated && off_ok) begin
              mode_avg <= 1'b0;
              if (right_near) begin
                p_svalid        <= 1'b1;
                p_step          <= right_far ? 3'sd2 : 3'sd1;
                offcentre_count <= offcentre_count + 7'd1;
              end else if (left_near) begin
                p_svalid        <= 1'b1;
                p_step          <= left_far ? -3'sd2 : -3'sd1;
                offcentre_count <= offcentre_count + 7'd1;
              end else begin
                offcentre_count <= '0;
              end
            end else begin
              mode_avg <= 1'b1;
              if (recal) begin
                p_svalid        <= 1'b1;
                offcentre_count <= '0;
                calib_count     <= '0;
                centre_reg      <= CENTRE_RESET;
              end
              if (steer != 8'd0) begin
                calib_count <= cc_new;
              end
            end
          end
        end
        S_DIV: begin
          if (div_stat.done) begin
            state <= S_DONE;
            if (mode_avg) begin
              centre_reg <= quot[7:0];
              drift_reg  <= DRIFT_W'(quot[7:0]) << DRIFT_FRAC_BITS;
            end else begin
              drift_reg <= drift_new;
              if (re_centre) begin
                centre_reg <= drift_new[DRIFT_W-1:DRIFT_FRAC_BITS];
              end
            end
          end
        end
        S_DONE: begin
          if (out_free) begin
            out_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (state == S_DONE && out_free) begin
      intensity_up   <= p_btn.up;
      intensity_down <= p_btn.down;
      start_request  <= p_btn.start;
      lap_request    <= p_btn.lap;
      stop_request   <= p_btn.stop;
      scroll_valid   <= p_svalid;
      scroll_step    <= p_step;
      centre_value   <= centre_reg;
    end
  end

  a_no_step_without_valid: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (scroll_valid || scroll_step == 3'sd0))
    else $error("scroll step without scroll valid");

  a_step_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (scroll_step != 3'sd3 && scroll_step != -3'sd3 && scroll_step != -3'sd4))
    else $error("scroll step out of range");

  a_div_done_in_div: assert property (@(posedge clk) disable iff (rst)
    div_stat.done |-> state == S_DIV)
    else $error("divider finished outside divide state");

  a_div_state_active: assert property (@(posedge clk) disable iff (rst)
    state == S_DIV |-> (div_stat.busy || div_stat.done))
    else $error("waiting on idle divider");

endmodule

`default_nettype wire

// ----- design/hbsq_btn.sv -----
// hbsq_btn: release and hold counters and button request decode
// depends on hbsq_pkg
`default_nettype none

module hbsq_btn #(
  parameter int COUNT_LIMIT = hbsq_pkg::DEFAULT_COUNT_LIMIT
) (
  input  wire                  clk,
  input  wire                  rst,
  input  wire                  update,
  input  wire [7:0]            buttons,
  input  wire                  running,
  input  wire                  paused,
  input  wire hbsq_pkg::btn_cfg_t cfg,
  output hbsq_pkg::btn_req_t   req
);
  import hbsq_pkg::*;

  localparam logic [CNT_W-1:0] LIMIT = CNT_W'(COUNT_LIMIT);

  logic [CNT_W-1:0] release_count;
  logic [CNT_W-1:0] hold_count;
  logic [CNT_W-1:0] hold_next;
  logic             idle;
  logic             rep;
  logic             once;

  assign idle      = (buttons == IDLE_BUTTONS);
  assign hold_next = (hold_count < LIMIT) ? hold_count + 7'd1 : hold_count;
  assign rep       = (release_count != '0) || (hold_next > REPEAT_AFTER);
  assign once      = (release_count > SINGLE_AFTER);

  always_comb begin
    req = '0;
    if (!idle) begin
      req.up   = ((buttons & cfg.plus_mask) == 8'd0) && rep;
      req.down = ((buttons & cfg.minus_mask) == 8'd0) && rep;
      if (((buttons & cfg.enter_mask) == 8'd0) && once) begin
        if (!running || paused) begin
          req.start = 1'b1;
        end else begin
          req.lap = 1'b1;
        end
      end
      if (((buttons & cfg.cancel_mask) == 8'd0) && once && running) begin
        if (paused) begin
          req.stop = 1'b1;
        end else begin
          req.start = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      release_count <= '0;
      hold_count    <= '0;
    end else if (update) begin
      if (idle) begin
        if (release_count < LIMIT) begin
          release_count <= release_count + 7'd1;
        end
        hold_count <= '0;
      end else begin
        hold_count    <= hold_next;
        release_count <= '0;
      end
    end
  end

endmodule

`default_nettype wire

// ----- design/hbsq_div.sv -----
// hbsq_div: shared restoring divider, one quotient bit per cycle
// depends on hbsq_pkg
`default_nettype none

module hbsq_div #(
  parameter int NUM_W = 20
) (
  input  wire                         clk,
  input  wire                         rst,
  input  wire                         start,
  input  wire [NUM_W-1:0]             numer,
  input  wire [hbsq_pkg::DEN_W-1:0]   denom,
  output logic [NUM_W-1:0]            quot,
  output hbsq_pkg::div_stat_t         stat
);
  import hbsq_pkg::*;

  localparam int CW = $clog2(NUM_W + 1);

  logic [NUM_W-1:0] acc;
  logic [DEN_W-1:0] rem;
  logic [DEN_W-1:0] den;
  logic [CW-1:0]    cnt;
  logic             busy;
  logic             done;
  logic [DEN_W:0]   trial;
  logic             fit;

  assign trial = {rem, acc[NUM_W-1]};
  assign fit   = (trial >= {1'b0, den});
  assign quot  = acc;

  always_comb begin
    stat.busy = busy;
    stat.done = done;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CW'(NUM_W);
      end else if (busy) begin
        cnt <= cnt - CW'(1);
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      acc <= numer;
      rem <= '0;
      den <= denom;
    end else if (busy) begin
      acc <= {acc[NUM_W-2:0], fit};
      if (fit) begin
        rem <= DEN_W'(trial - {1'b0, den});
      end else begin
        rem <= trial[DEN_W-1:0];
      end
    end
  end

endmodule

`default_nettype wire

// ----- tb/sv/testbench.sv -----
// testbench for handlebar_button_steer_qualifier: directed and random poll samples with random idling
// on both sides, checked against a scoreboard that predicts every result
// depends on hbsq_pkg and handlebar_button_steer_qualifier
`default_nettype none

module testbench;
  import hbsq_pkg::*;

  localparam int FRAC       = DEFAULT_DRIFT_FRAC_BITS;
  localparam int HOLD_LIMIT = DEFAULT_COUNT_LIMIT;
  localparam int LIMIT      = 400000;

  typedef struct packed {
    logic up;
    logic down;
    logic start;
    logic lap;
    logic stop;
    logic svalid;
    logic signed [2:0] step;
    logic [7:0] centre;
  } poll_result_t;

  class qualifier_scoreboard;
    logic [7:0] plus_m, minus_m, enter_m, cancel_m;
    int calib_need, act_limit, near_w, far_w;
    int release_cnt, hold_cnt, calib_cnt, offc_cnt, centre, drift;
    poll_result_t expected_q[$];
    int fails;

    function new();
      plus_m = RST_PLUS_MASK;
      minus_m = RST_MINUS_MASK;
      enter_m = RST_ENTER_MASK;
      cancel_m = RST_CANCEL_MASK;
      calib_need = int'(RST_CALIB_SAMPLES);
      act_limit = int'(RST_ACTIVE_LIMIT);
      near_w = int'(RST_NEAR_BAND);
      far_w = int'(RST_FAR_BAND);
      release_cnt = 0;
      hold_cnt = 0;
      calib_cnt = 0;
      offc_cnt = 0;
      centre = int'(CENTRE_RESET);
      drift = int'(CENTRE_RESET) << FRAC;
      fails = 0;
    endfunction

    function void set_reg(logic [2:0] idx, logic [7:0] val);
      case (idx)
        REG_PLUS_MASK:     plus_m = val;
        REG_MINUS_MASK:    minus_m = val;
        REG_ENTER_MASK:    enter_m = val;
        REG_CANCEL_MASK:   cancel_m = val;
        REG_CALIB_SAMPLES: calib_need = int'(val[5:0]);
        REG_ACTIVE_LIMIT:  act_limit = int'(val[6:0]);
        REG_NEAR_BAND:     near_w = int'(val[6:0]);
        REG_FAR_BAND:      far_w = int'(val[6:0]);
        default: ;
      endcase
    endfunction

    function void note_request(logic [7:0] btn, logic [7:0] steer_in, logic cal, logic run,
                               logic pau);
      poll_result_t r;
      bit rep, once;
      int steer, num, diff, one, sstep, drift_mask;
      r = '0;
      sstep = 0;
      steer = int'(steer_in);
      one = 1 << FRAC;
      drift_mask = (1 << (8 + FRAC)) - 1;
      if (!cal) begin
        if (btn == IDLE_BUTTONS) begin
          if (release_cnt < HOLD_LIMIT) release_cnt++;
          hold_cnt = 0;
        end else begin
          if (hold_cnt < HOLD_LIMIT) hold_cnt++;
          rep = release_cnt > 0 || hold_cnt > int'(REPEAT_AFTER);
          once = release_cnt > int'(SINGLE_AFTER);
          if ((btn & plus_m) == 0 && rep) r.up = 1'b1;
          if ((btn & minus_m) == 0 && rep) r.down = 1'b1;
          if ((btn & enter_m) == 0 && once) begin
            if (!run || pau) r.start = 1'b1;
            else r.lap = 1'b1;
          end
          if ((btn & cancel_m) == 0 && once && run) begin
            if (pau) r.stop = 1'b1;
            else r.start = 1'b1;
          end
          release_cnt = 0;
        end

        if (calib_cnt > calib_need && offc_cnt < act_limit) begin
          if (steer > centre + near_w) begin
            r.svalid = 1'b1;
            sstep = (steer > centre + far_w) ? 2 : 1;
            offc_cnt++;
          end else if (steer < centre - near_w) begin
            r.svalid = 1'b1;
            sstep = (steer < centre - far_w) ? -2 : -1;
            offc_cnt++;
          end else begin
            offc_cnt = 0;
            num = drift * 9 + (steer << FRAC);
            drift = (num / 10) & drift_mask;
            diff = drift - (centre << FRAC);
            if (diff > one || diff < -one) centre = (drift >> FRAC) & 'hff;
          end
        end else begin
          if (offc_cnt >= act_limit) begin
            calib_cnt = 0;
            offc_cnt = 0;
            centre = int'(CENTRE_RESET);
            r.svalid = 1'b1;
          end
          if (steer > 0) begin
            if (calib_cnt < int'(CALIB_MAX)) calib_cnt++;
            centre = ((centre * calib_cnt + steer) / (calib_cnt + 1)) & 'hff;
            drift = (centre << FRAC) & drift_mask;
          end
        end
      end
      r.step = 3'(sstep);
      r.centre = centre[7:0];
      expected_q.push_back(r);
    endfunction

    function void compare(string field, int want, int got);
      if (want != got) begin
        $error("%s: expected %0d, got %0d", field, want, got);
        fails++;
      end
    endfunction

    function void check_result(poll_result_t got);
      poll_result_t want;
      if (expected_q.size() == 0) begin
        $error("result with no request outstanding");
        fails++;
        return;
      end
      want = expected_q.pop_front();
      compare("intensity_up", want.up, got.up);
      compare("intensity_down", want.down, got.down);
      compare("start_request", want.start, got.start);
      compare("lap_request", want.lap, got.lap);
      compare("stop_request", want.stop, got.stop);
      compare("scroll_valid", want.svalid, got.svalid);
      compare("scroll_step", want.step, got.step);
      compare("centre_value", want.centre, got.centre);
    endfunction
  endclass

  logic clk;
  logic rst = 1'b1;
  logic cfg_write = 1'b0;
  logic [2:0] cfg_index = REG_PLUS_MASK;
  logic [7:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [7:0] button_bits = IDLE_BUTTONS;
  logic [7:0] steer_sample = '0;
  logic calibrating_flag = 1'b0;
  logic session_running = 1'b0;
  logic session_paused = 1'b0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic intensity_up, intensity_down, start_request, lap_request, stop_request;
  logic scroll_valid;
  logic signed [2:0] scroll_step;
  logic [7:0] centre_value;

  qualifier_scoreboard sb;
  logic [7:0] cfg_vals [8];
  int idle_pct = 0;
  int cycle_count = 0;

  handlebar_button_steer_qualifier dut (
    .clk(clk),
    .rst(rst),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .button_bits(button_bits),
    .steer_sample(steer_sample),
    .calibrating_flag(calibrating_flag),
    .session_running(session_running),
    .session_paused(session_paused),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .intensity_up(intensity_up),
    .intensity_down(intensity_down),
    .start_request(start_request),
    .lap_request(lap_request),
    .stop_request(stop_request),
    .scroll_valid(scroll_valid),
    .scroll_step(scroll_step),
    .centre_value(centre_value)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    while (cycle_count < LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("FAIL");
    $finish;
  end

  // receiver stalls
  initial begin
    while (rst) @(posedge clk);
    forever begin
      @(posedge clk);
      if (idle_pct > 0 && $urandom_range(0, 99) < idle_pct) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 12)) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    poll_result_t got;
    if (!rst && out_valid && !out_stall) begin
      got.up = intensity_up;
      got.down = intensity_down;
      got.start = start_request;
      got.lap = lap_request;
      got.stop = stop_request;
      got.svalid = scroll_valid;
      got.step = scroll_step;
      got.centre = centre_value;
      sb.check_result(got);
    end
  end

  task automatic put_reg(input logic [2:0] idx);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= cfg_vals[idx];
    @(posedge clk);
    sb.set_reg(idx, cfg_vals[idx]);
  endtask

  task automatic apply_cfg();
    put_reg(REG_PLUS_MASK);
    put_reg(REG_MINUS_MASK);
    put_reg(REG_ENTER_MASK);
    put_reg(REG_CANCEL_MASK);
    put_reg(REG_CALIB_SAMPLES);
    put_reg(REG_ACTIVE_LIMIT);
    put_reg(REG_NEAR_BAND);
    put_reg(REG_FAR_BAND);
    cfg_write <= 1'b0;
  endtask

  task automatic send_poll(input logic [7:0] b, input logic [7:0] s, input logic cal,
                           input logic run, input logic pau);
    in_valid <= 1'b1;
    button_bits <= b;
    steer_sample <= s;
    calibrating_flag <= cal;
    session_running <= run;
    session_paused <= pau;
    do @(posedge clk); while (in_stall);
    sb.note_request(b, s, cal, run, pau);
    if (idle_pct > 0 && $urandom_range(0, 99) < idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
  endtask

  // drop valid and let every outstanding request drain
  task automatic settle();
    in_valid <= 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (30) @(posedge clk);
  endtask

  task automatic random_phase(input int n_items);
    int idle_left, press_left, burst_left, burst_off, aim, s;
    logic [7:0] press_byte, b;
    logic cal, run, pau;
    aim = $urandom_range(40, 215);
    idle_left = 0;
    press_left = 0;
    burst_left = 0;
    burst_off = 0;
    press_byte = IDLE_BUTTONS;
    run = 1'($urandom_range(0, 1));
    pau = 1'($urandom_range(0, 1));
    for (int k = 0; k < n_items; k++) begin
      if (idle_left == 0 && press_left == 0) begin
        idle_left = $urandom_range(0, 8);
        press_left = $urandom_range(1, 10);
        case ($urandom_range(0, 3))
          0: press_byte = IDLE_BUTTONS & ~cfg_vals[$urandom_range(0, 3)];
          1: press_byte = IDLE_BUTTONS & 8'($urandom);
          default: press_byte = 8'($urandom);
        endcase
        if ($urandom_range(0, 2) == 0) begin
          run = 1'($urandom_range(0, 1));
          pau = 1'($urandom_range(0, 1));
        end
      end
      if (idle_left > 0) begin
        b = IDLE_BUTTONS;
        idle_left--;
      end else begin
        b = press_byte;
        press_left--;
      end
      if (burst_left > 0) begin
        s = aim + burst_off;
        burst_left--;
      end else begin
        case ($urandom_range(0, 9))
          0: s = 0;
          1: s = $urandom_range(0, 255);
          2: begin
            burst_left = $urandom_range(1, 30);
            burst_off = $urandom_range(5, 60);
            if ($urandom_range(0, 1)) burst_off = -burst_off;
            s = aim + burst_off;
          end
          default: s = aim + $urandom_range(0, 24) - 12;
        endcase
      end
      if (s < 0) s = 0;
      if (s > 255) s = 255;
      if ($urandom_range(0, 9) == 0) aim = aim + $urandom_range(0, 6) - 3;
      cal = ($urandom_range(0, 19) == 0);
      send_poll(b, s[7:0], cal, run, pau);
    end
  endtask

  initial begin
    sb = new();
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // directed part: short calibration, small off-centre limit
    cfg_vals[REG_PLUS_MASK] = RST_PLUS_MASK;
    cfg_vals[REG_MINUS_MASK] = RST_MINUS_MASK;
    cfg_vals[REG_ENTER_MASK] = RST_ENTER_MASK;
    cfg_vals[REG_CANCEL_MASK] = RST_CANCEL_MASK;
    cfg_vals[REG_CALIB_SAMPLES] = 8'd1;
    cfg_vals[REG_ACTIVE_LIMIT] = 8'd3;
    cfg_vals[REG_NEAR_BAND] = 8'(RST_NEAR_BAND);
    cfg_vals[REG_FAR_BAND] = 8'(RST_FAR_BAND);
    apply_cfg();
    send_poll(8'h00, 8'hff, 1'b1, 1'b1, 1'b1);
    send_poll(IDLE_BUTTONS, 8'd0, 1'b0, 1'b0, 1'b0);
    repeat (2) send_poll(IDLE_BUTTONS, 8'd130, 1'b0, 1'b0, 1'b0);
    send_poll(IDLE_BUTTONS, 8'd0, 1'b0, 1'b0, 1'b0);
    send_poll(IDLE_BUTTONS, 8'd255, 1'b0, 1'b0, 1'b0);
    send_poll(IDLE_BUTTONS & ~RST_ENTER_MASK, 8'd255, 1'b0, 1'b0, 1'b0);
    repeat (6) send_poll(IDLE_BUTTONS & ~RST_PLUS_MASK, 8'd140, 1'b0, 1'b0, 1'b0);
    repeat (5) send_poll(IDLE_BUTTONS, 8'd128, 1'b0, 1'b1, 1'b0);
    send_poll(8'h00, 8'd128, 1'b0, 1'b1, 1'b0);
    repeat (5) send_poll(IDLE_BUTTONS, 8'd118, 1'b0, 1'b1, 1'b1);
    send_poll(IDLE_BUTTONS & ~RST_CANCEL_MASK, 8'd138, 1'b0, 1'b1, 1'b1);
    settle();

    for (int p = 0; p < 8; p++) begin
      case (p)
        0: begin
          cfg_vals[REG_PLUS_MASK] = RST_PLUS_MASK;
          cfg_vals[REG_MINUS_MASK] = RST_MINUS_MASK;
          cfg_vals[REG_ENTER_MASK] = RST_ENTER_MASK;
          cfg_vals[REG_CANCEL_MASK] = RST_CANCEL_MASK;
          cfg_vals[REG_CALIB_SAMPLES] = 8'd0;
          cfg_vals[REG_ACTIVE_LIMIT] = 8'd0;
          cfg_vals[REG_NEAR_BAND] = 8'd0;
          cfg_vals[REG_FAR_BAND] = 8'd0;
        end
        1: begin
          cfg_vals[REG_PLUS_MASK] = 8'h00;
          cfg_vals[REG_MINUS_MASK] = 8'h00;
          cfg_vals[REG_ENTER_MASK] = 8'h00;
          cfg_vals[REG_CANCEL_MASK] = 8'h00;
          cfg_vals[REG_CALIB_SAMPLES] = 8'd1;
          cfg_vals[REG_ACTIVE_LIMIT] = 8'd127;
          cfg_vals[REG_NEAR_BAND] = 8'd127;
          cfg_vals[REG_FAR_BAND] = 8'd127;
        end
        2: begin
          cfg_vals[REG_PLUS_MASK] = 8'hff;
          cfg_vals[REG_MINUS_MASK] = 8'hff;
          cfg_vals[REG_ENTER_MASK] = 8'hff;
          cfg_vals[REG_CANCEL_MASK] = 8'hff;
          cfg_vals[REG_CALIB_SAMPLES] = 8'd63;
          cfg_vals[REG_ACTIVE_LIMIT] = 8'd1;
          cfg_vals[REG_NEAR_BAND] = 8'd0;
          cfg_vals[REG_FAR_BAND] = 8'd127;
        end
        7: begin
          cfg_vals[REG_PLUS_MASK] = RST_PLUS_MASK;
          cfg_vals[REG_MINUS_MASK] = RST_MINUS_MASK;
          cfg_vals[REG_ENTER_MASK] = RST_ENTER_MASK;
          cfg_vals[REG_CANCEL_MASK] = RST_CANCEL_MASK;
          cfg_vals[REG_CALIB_SAMPLES] = 8'(RST_CALIB_SAMPLES);
          cfg_vals[REG_ACTIVE_LIMIT] = 8'(RST_ACTIVE_LIMIT);
          cfg_vals[REG_NEAR_BAND] = 8'(RST_NEAR_BAND);
          cfg_vals[REG_FAR_BAND] = 8'(RST_FAR_BAND);
        end
        default: begin
          cfg_vals[REG_PLUS_MASK] = ($urandom_range(0, 3) == 0) ? 8'($urandom)
                                    : 8'h10 << $urandom_range(0, 3);
          cfg_vals[REG_MINUS_MASK] = 8'h10 << $urandom_range(0, 3);
          cfg_vals[REG_ENTER_MASK] = 8'h10 << $urandom_range(0, 3);
          cfg_vals[REG_CANCEL_MASK] = ($urandom_range(0, 3) == 0) ? 8'($urandom)
                                      : 8'h10 << $urandom_range(0, 3);
          cfg_vals[REG_CALIB_SAMPLES] = 8'($urandom_range(0, 8));
          cfg_vals[REG_ACTIVE_LIMIT] = 8'($urandom_range(2, 20));
          cfg_vals[REG_NEAR_BAND] = 8'($urandom_range(0, 16));
          cfg_vals[REG_FAR_BAND] = 8'(cfg_vals[REG_NEAR_BAND] + $urandom_range(0, 20));
        end
      endcase
      apply_cfg();
      idle_pct = (p == 1 || p == 4 || p == 7) ? 0 : $urandom_range(5, 30);
      random_phase((p == 7) ? 110 : 55);
      settle();
    end

    if (sb.fails == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

`default_nettype wire
